// ===== design/html_entity_decoder_unit_defines.svh =====
// Assertion macros shared by the HTML entity decoder modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef HTML_ENTITY_DECODER_UNIT_DEFINES_SVH
`define HTML_ENTITY_DECODER_UNIT_DEFINES_SVH
// Same-cycle implication, disabled during reset.
`define HED_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define HED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/hed_pkg.sv =====
// Package for the HTML entity decoder: request types, command type, states,
// character codes and the name and UTF-8 helper functions. No dependencies.
package hed_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_req_t;

	localparam int CP_W = 21;
	localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
	localparam int CMDQ_DEPTH = 4;

	// One command from the front to the back: a raw byte or a code point.
	typedef struct packed {
		logic            raw;
		logic            last;
		logic [CP_W-1:0] cp;
	} cmd_t;

	typedef enum logic [2:0] {
		F_RUN, F_NX, F_NWS, F_NSG, F_NP0, F_NP1, F_NP2, F_NDG
	} front_state_t;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [4:0] DIG_NONE = 5'd31;

	// Digit value of a byte, DIG_NONE when it is no hex digit.
	function automatic logic [4:0] digit_value(input logic [7:0] c);
		logic [4:0] r;
		r = DIG_NONE;
		if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h37);
		return r;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// Code point of a named reference; key holds the first six body bytes.
	function automatic logic [CP_W-1:0] name_lookup(input logic [47:0] key,
		input logic [2:0] len);
		logic [CP_W-1:0] r;
		r = '0;
		if (len == 3'd3 && key[47:24] == "amp") r = 21'd38;
		if (len == 3'd2 && key[47:32] == "lt") r = 21'd60;
		if (len == 3'd2 && key[47:32] == "gt") r = 21'd62;
		if (len == 3'd4 && key[47:16] == "quot") r = 21'd34;
		if (len == 3'd4 && key[47:16] == "apos") r = 21'd39;
		if (len == 3'd4 && key[47:16] == "nbsp") r = 21'd32;
		if (len == 3'd6 && key == "hellip") r = 21'h2026;
		if (len == 3'd5 && key[47:8] == "mdash") r = 21'h2014;
		if (len == 3'd5 && key[47:8] == "ndash") r = 21'h2013;
		if (len == 3'd5 && key[47:8] == "rsquo") r = 21'h2019;
		if (len == 3'd5 && key[47:8] == "lsquo") r = 21'h2018;
		if (len == 3'd5 && key[47:8] == "ldquo") r = 21'h201C;
		if (len == 3'd5 && key[47:8] == "rdquo") r = 21'h201D;
		if (len == 3'd6 && key == "middot") r = 21'h00B7;
		if (len == 3'd3 && key[47:24] == "deg") r = 21'h00B0;
		if (len == 3'd5 && key[47:8] == "times") r = 21'h00D7;
		if (len == 3'd4 && key[47:16] == "copy") r = 21'h00A9;
		if (len == 3'd5 && key[47:8] == "trade") r = 21'h2122;
		if (len == 3'd3 && key[47:24] == "reg") r = 21'h00AE;
		if (len == 3'd6 && key == "eacute") r = 21'h00E9;
		if (len == 3'd6 && key == "egrave") r = 21'h00E8;
		if (len == 3'd4 && key[47:16] == "bull") r = 21'h2022;
		if (len == 3'd5 && key[47:8] == "prime") r = 21'h2032;
		if (len == 3'd5 && key[47:8] == "Prime") r = 21'h2033;
		return r;
	endfunction

	// Number of UTF-8 bytes minus one.
	function automatic logic [1:0] utf8_len(input logic [CP_W-1:0] cp);
		logic [1:0] r;
		if (cp < 21'h80) r = 2'd0;
		else if (cp < 21'h800) r = 2'd1;
		else if (cp < 21'h10000) r = 2'd2;
		else r = 2'd3;
		return r;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
		input logic [1:0] idx);
		logic [7:0] r;
		r = cp[7:0];
		case (utf8_len(cp))
			2'd1: r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			2'd2: begin
				case (idx)
					2'd0: r = {4'b1110, cp[15:12]};
					2'd1: r = {2'b10, cp[11:6]};
					default: r = {2'b10, cp[5:0]};
				endcase
			end
			2'd3: begin
				case (idx)
					2'd0: r = {5'b11110, cp[20:18]};
					2'd1: r = {2'b10, cp[17:12]};
					2'd2: r = {2'b10, cp[11:6]};
					default: r = {2'b10, cp[5:0]};
				endcase
			end
			default: r = cp[7:0];
		endcase
		return r;
	endfunction

endpackage

// ===== design/hed_front.sv =====
// Front of the HTML entity decoder: accepts bytes, keeps a rescan line,
// recognizes references and sends commands to the queue. Uses hed_pkg.
module hed_front #(
	parameter int MAX_SPAN = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  hed_pkg::in_req_t in_req,
	output logic             push,
	output hed_pkg::cmd_t    push_cmd,
	input  logic             full
);
	import hed_pkg::*;

	localparam int BDEPTH = (MAX_SPAN - 1 > 6) ? MAX_SPAN - 1 : 6;
	localparam int BIW = $clog2(BDEPTH);
	localparam int BLW = $clog2(BDEPTH + 1);
	localparam int AW = $clog2(MAX_SPAN + 1);
	localparam int DEPTH = 1 << AW;

	logic [7:0]      line_q [DEPTH];
	logic [7:0]      body_q [BDEPTH];
	logic [AW-1:0]   wp_q, rp_q, ap_q, rp_d, ap_d;
	logic            pend_q, pend_d, last_q;
	logic [BLW-1:0]  bl_q, bl_d, p_q, p_d, p0_q, p0_d;
	logic            hex_q, hex_d, cnt_q, cnt_d;
	logic [21:0]     v_q, v_d;
	front_state_t    state_q, state_d;
	cmd_t            held_q, emit_cmd;
	logic            held_v_q, emit, flush, fail, body_we, ok, empty, pvalid;
	logic [7:0]      c, bc;
	logic [4:0]      d;
	logic [47:0]     key;
	logic [CP_W-1:0] nm_cp;
	logic [25:0]     acc;

	assign c = line_q[rp_q];
	assign bc = body_q[p_q[BIW-1:0]];
	assign empty = (rp_q == wp_q);
	assign ok = !(held_v_q && full);
	assign pvalid = (p_q < bl_q);
	assign d = digit_value(bc);

	// First six body bytes for the name compare.
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			key[47-8*i -: 8] = body_q[BIW'(i)];
		end
	end
	assign nm_cp = (bl_q <= BLW'(6)) ? name_lookup(key, bl_q[2:0]) : '0;

	// Next accumulator value, saturated above the largest code point.
	always_comb begin
		acc = hex_q ? {v_q, 4'b0} : ({4'b0, v_q} << 3) + ({4'b0, v_q} << 1);
		acc = acc + 26'(d);
		if (acc > 26'(CP_MAX)) acc = 26'(CP_MAX) + 26'd1;
	end

	// Byte processing and serial number parse.
	always_comb begin
		state_d = state_q;
		rp_d = rp_q;
		ap_d = ap_q;
		pend_d = pend_q;
		bl_d = bl_q;
		p_d = p_q;
		p0_d = p0_q;
		hex_d = hex_q;
		cnt_d = cnt_q;
		v_d = v_q;
		body_we = 1'b0;
		emit = 1'b0;
		emit_cmd = '0;
		flush = 1'b0;
		fail = 1'b0;
		in_stall = 1'b1;
		if (ok) begin
			unique case (state_q)
				F_RUN: begin
					if (!empty) begin
						rp_d = rp_q + AW'(1);
						if (!pend_q) begin
							if (c == CH_AMP) begin
								pend_d = 1'b1;
								bl_d = '0;
								ap_d = rp_q;
							end else begin
								emit = 1'b1;
								emit_cmd = '{raw: 1'b1, last: 1'b0, cp: CP_W'(c)};
							end
						end else if (c == CH_SEMI) begin
							if (bl_q != '0 && body_q[0] == CH_HASH) begin
								state_d = F_NX;
								p_d = BLW'(1);
								hex_d = 1'b0;
								cnt_d = 1'b0;
								v_d = '0;
							end else if (nm_cp != '0) begin
								emit = 1'b1;
								emit_cmd = '{raw: 1'b0, last: 1'b0, cp: nm_cp};
								pend_d = 1'b0;
								bl_d = '0;
							end else begin
								fail = 1'b1;
							end
						end else if (bl_q < BLW'(MAX_SPAN - 1)) begin
							body_we = 1'b1;
							bl_d = bl_q + BLW'(1);
						end else begin
							fail = 1'b1;
						end
					end else if (last_q && pend_q) begin
						fail = 1'b1;
					end else begin
						flush = held_v_q;
						in_stall = 1'b0;
					end
				end
				F_NX: begin
					if (pvalid && (bc == CH_LX || bc == CH_UX)) begin
						hex_d = 1'b1;
						p_d = p_q + BLW'(1);
					end
					state_d = F_NWS;
				end
				F_NWS: begin
					if (pvalid && is_ws(bc)) p_d = p_q + BLW'(1);
					else state_d = F_NSG;
				end
				F_NSG: begin
					if (pvalid && bc == CH_MINUS) begin
						state_d = F_RUN;
						fail = 1'b1;
					end else begin
						if (pvalid && bc == CH_PLUS) p_d = p_q + BLW'(1);
						state_d = hex_q ? F_NP0 : F_NDG;
					end
				end
				F_NP0: begin
					if (({1'b0, p_q} + (BLW+1)'(2)) < {1'b0, bl_q} && bc == CH_ZERO) begin
						p0_d = p_q;
						p_d = p_q + BLW'(1);
						state_d = F_NP1;
					end else begin
						state_d = F_NDG;
					end
				end
				F_NP1: begin
					if (bc == CH_LX || bc == CH_UX) begin
						p_d = p_q + BLW'(1);
						state_d = F_NP2;
					end else begin
						p_d = p0_q;
						state_d = F_NDG;
					end
				end
				F_NP2: begin
					if (d >= 5'd16) p_d = p0_q;
					state_d = F_NDG;
				end
				F_NDG: begin
					if (pvalid && d < (hex_q ? 5'd16 : 5'd10)) begin
						v_d = acc[21:0];
						cnt_d = 1'b1;
						p_d = p_q + BLW'(1);
					end else begin
						state_d = F_RUN;
						if (cnt_q && p_q == bl_q && v_q != '0 && v_q <= 22'(CP_MAX)) begin
							emit = 1'b1;
							emit_cmd = '{raw: 1'b0, last: 1'b0, cp: v_q[CP_W-1:0]};
							pend_d = 1'b0;
							bl_d = '0;
						end else begin
							fail = 1'b1;
						end
					end
				end
				default: state_d = F_RUN;
			endcase
		end
		// A failed reference emits the ampersand and rescans its body.
		if (fail) begin
			emit = 1'b1;
			emit_cmd = '{raw: 1'b1, last: 1'b0, cp: CP_W'(CH_AMP)};
			rp_d = ap_q + AW'(1);
			pend_d = 1'b0;
			bl_d = '0;
		end
	end

	// The newest command is held back until it is known whether it ends the item.
	assign push = (emit && held_v_q) || flush;
	always_comb begin
		push_cmd = held_q;
		push_cmd.last = flush ? last_q : 1'b0;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_RUN;
			wp_q <= '0;
			rp_q <= '0;
			ap_q <= '0;
			pend_q <= 1'b0;
			bl_q <= '0;
			last_q <= 1'b0;
			held_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rp_q <= rp_d;
			ap_q <= ap_d;
			pend_q <= pend_d;
			bl_q <= bl_d;
			if (in_valid && !in_stall) begin
				wp_q <= wp_q + AW'(1);
				last_q <= in_req.in_last;
			end
			if (emit) held_v_q <= 1'b1;
			else if (flush) held_v_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		p_q <= p_d;
		p0_q <= p0_d;
		hex_q <= hex_d;
		cnt_q <= cnt_d;
		v_q <= v_d;
		if (emit) held_q <= emit_cmd;
		if (in_valid && !in_stall) line_q[wp_q] <= in_req.in_byte;
		if (body_we) body_q[bl_q[BIW-1:0]] <= c;
	end

endmodule

// ===== design/hed_cmdq.sv =====
// Command queue between the decoder front and back.
// Uses hed_pkg and the assertion macros of the defines header.
`include "html_entity_decoder_unit_defines.svh"
module hed_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hed_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output hed_pkg::cmd_t pop_cmd,
	output logic          empty
);
	import hed_pkg::*;

	localparam int QW = $clog2(CMDQ_DEPTH);

	cmd_t          mem_q [CMDQ_DEPTH];
	logic [QW-1:0] wr_q, rd_q;
	logic [QW:0]   count_q;

	assign full = (count_q == (QW+1)'(CMDQ_DEPTH));
	assign empty = (count_q == '0);
	assign pop_cmd = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QW'(1);
			if (pop) rd_q <= rd_q + QW'(1);
			count_q <= count_q + (QW+1)'(push) - (QW+1)'(pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_cmd;
	end

	`HED_ASSERT_NOW(a_no_overflow, push, !full || pop, "command pushed into a full queue")
	`HED_ASSERT_NOW(a_no_underflow, pop, !empty, "command popped from an empty queue")
	`HED_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "count did not rise")

endmodule

// ===== design/hed_back.sv =====
// Back of the HTML entity decoder: expands commands into output bytes
// and drives the output channel. Uses hed_pkg.
module hed_back (
	input  logic              clk,
	input  logic              arst_n,
	output logic              pop,
	input  hed_pkg::cmd_t     pop_cmd,
	input  logic              empty,
	output logic              out_valid,
	input  logic              out_stall,
	output hed_pkg::out_req_t out_req
);
	import hed_pkg::*;

	cmd_t       cmd_q;
	logic       have_q, take, last_byte;
	logic [1:0] idx_q, nlast;

	assign nlast = cmd_q.raw ? 2'd0 : utf8_len(cmd_q.cp);
	assign last_byte = (idx_q == nlast);
	assign out_valid = have_q;
	assign take = have_q && !out_stall;
	assign pop = (!have_q || (take && last_byte)) && !empty;

	// Current output byte of the held command.
	always_comb begin
		out_req.out_byte = cmd_q.raw ? cmd_q.cp[7:0] : utf8_byte(cmd_q.cp, idx_q);
		out_req.out_last = cmd_q.last && last_byte;
	end

	// Command register and byte index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			idx_q <= '0;
		end else if (pop) begin
			have_q <= 1'b1;
			idx_q <= '0;
		end else if (take && last_byte) begin
			have_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= pop_cmd;
	end

endmodule

// ===== design/html_entity_decoder_unit.sv =====
// HTML entity decoder: decodes character references in a byte stream into UTF-8.
// Top level; uses hed_pkg, hed_front, hed_cmdq and hed_back.
//
// Usage: bytes enter on in_valid / in_stall / in_req, a request carrying one
// text byte and its in_last mark. Decoded bytes leave on out_valid / out_stall /
// out_req, with out_last on the final byte caused by a marked input byte.
// A request is taken only when the front finds its rescan line empty, so
// each plain byte is processed in the front before the next one is taken.
// An ampersand body is stored byte by byte; a numeric body is then parsed
// serially: radix mark, white space, sign, 0x prefix and digits.
// A failed reference rescans its body through the front again.
// Output bytes lag the byte that causes them, since the newest command is
// held until the next one or the end of its item.
// Reset clears the front state, the command queue and the output stage; no
// clearing pass is needed. When the receiver stalls, the back holds its byte,
// the four-entry command queue fills, and then the front stops taking requests.
module html_entity_decoder_unit #(
	parameter int MAX_SPAN = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  hed_pkg::in_req_t  in_req,
	output logic              out_valid,
	input  logic              out_stall,
	output hed_pkg::out_req_t out_req
);
	import hed_pkg::*;

	cmd_t push_cmd, pop_cmd;
	logic push, full, pop, empty;

	// Front: reference recognition.
	hed_front #(.MAX_SPAN(MAX_SPAN)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
		.push(push), .push_cmd(push_cmd), .full(full)
	);

	// Queue between front and back.
	hed_cmdq u_cmdq (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_cmd(push_cmd), .full(full),
		.pop(pop), .pop_cmd(pop_cmd), .empty(empty)
	);

	// Back: UTF-8 expansion and output channel.
	hed_back u_back (
		.clk(clk), .arst_n(arst_n),
		.pop(pop), .pop_cmd(pop_cmd), .empty(empty),
		.out_valid(out_valid), .out_stall(out_stall), .out_req(out_req)
	);

endmodule

// ===== bench/html_entity_decoder_unit_tb.sv =====
// Testbench for html_entity_decoder_unit: drives text byte requests and checks decoded UTF-8.
// Depends on hed_pkg and the html_entity_decoder_unit RTL; self-contained otherwise.
`timescale 1ns / 100ps

module html_entity_decoder_unit_tb;
	import hed_pkg::*;

	localparam int SPAN = 12;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_req_t in_req;
	logic out_valid;
	logic out_stall;
	out_req_t out_req;

	// Decoder model state.
	bit amp_open;
	bit [7:0] body_bytes [SPAN-1];
	int body_len;

	out_req_t decoded_q[$];
	int error_count;
	int idle_cycles;
	int bytes_sent;
	int bytes_checked;
	bit hold_off;
	bit rx_random;

	html_entity_decoder_unit #(.MAX_SPAN(SPAN)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
		.out_valid(out_valid), .out_stall(out_stall), .out_req(out_req)
	);

	// Clock generation.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Report one mismatch and count it.
	task automatic report_error(input string what);
		$display("ERROR at %0t: %s", $realtime, what);
		error_count++;
	endtask

	function automatic int hex_digit(input bit [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return 99;
	endfunction

	function automatic bit is_space(input bit [7:0] c);
		return c == " " || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// Returns the code point of a numeric body, or zero when it is rejected.
	function automatic int unsigned numeric_value();
		int p, radix, digits;
		int unsigned v;
		p = 1;
		radix = 10;
		digits = 0;
		v = 0;
		if (p < body_len && (body_bytes[p] == CH_LX || body_bytes[p] == CH_UX)) begin
			radix = 16;
			p++;
		end
		while (p < body_len && is_space(body_bytes[p])) p++;
		if (p < body_len && body_bytes[p] == CH_MINUS) return 0;
		if (p < body_len && body_bytes[p] == CH_PLUS) p++;
		if (radix == 16 && p + 2 < body_len && body_bytes[p] == CH_ZERO &&
			(body_bytes[p+1] == CH_LX || body_bytes[p+1] == CH_UX) &&
			hex_digit(body_bytes[p+2]) < 16)
			p += 2;
		while (p < body_len && hex_digit(body_bytes[p]) < radix) begin
			v = v * radix + hex_digit(body_bytes[p]);
			if (v > 32'h10FFFF) v = 32'h110000;
			p++;
			digits++;
		end
		if (digits == 0 || p != body_len || v == 0 || v > 32'h10FFFF) return 0;
		return v;
	endfunction

	// Returns the code point of the buffered body, or zero when it is not handled.
	function automatic int unsigned body_code_point();
		string s;
		if (body_len > 0 && body_bytes[0] == CH_HASH) return numeric_value();
		s = "";
		// A zero byte would vanish from the string, and no name holds one.
		for (int i = 0; i < body_len; i++) begin
			if (body_bytes[i] == 8'h00) return 0;
			s = {s, string'(body_bytes[i])};
		end
		case (s)
			"amp": return 38;
			"lt": return 60;
			"gt": return 62;
			"quot": return 34;
			"apos": return 39;
			"nbsp": return 32;
			"hellip": return 'h2026;
			"mdash": return 'h2014;
			"ndash": return 'h2013;
			"rsquo": return 'h2019;
			"lsquo": return 'h2018;
			"ldquo": return 'h201C;
			"rdquo": return 'h201D;
			"middot": return 'hB7;
			"deg": return 'hB0;
			"times": return 'hD7;
			"copy": return 'hA9;
			"trade": return 'h2122;
			"reg": return 'hAE;
			"eacute": return 'hE9;
			"egrave": return 'hE8;
			"bull": return 'h2022;
			"prime": return 'h2032;
			"Prime": return 'h2033;
			default: return 0;
		endcase
	endfunction

	// Encodes one code point as UTF-8 bytes.
	task automatic push_utf8(input int unsigned cp, ref bit [7:0] res[$]);
		if (cp < 'h80) begin
			res.push_back(cp[7:0]);
		end else if (cp < 'h800) begin
			res.push_back(8'hC0 | cp[10:6]);
			res.push_back(8'h80 | cp[5:0]);
		end else if (cp < 'h10000) begin
			res.push_back(8'hE0 | cp[15:12]);
			res.push_back(8'h80 | cp[11:6]);
			res.push_back(8'h80 | cp[5:0]);
		end else begin
			res.push_back(8'hF0 | cp[20:18]);
			res.push_back(8'h80 | cp[17:12]);
			res.push_back(8'h80 | cp[11:6]);
			res.push_back(8'h80 | cp[5:0]);
		end
	endtask

	// A failed reference emits '&' and puts the body and the byte in hand back in front.
	task automatic abandon_ref(input bit with_byte, input bit [7:0] c,
		ref bit [7:0] pend[$], ref bit [7:0] res[$]);
		bit [7:0] head[$];
		res.push_back(CH_AMP);
		for (int i = 0; i < body_len; i++) head.push_back(body_bytes[i]);
		if (with_byte) head.push_back(c);
		pend = {head, pend};
		amp_open = 0;
		body_len = 0;
	endtask

	// Works out the decoded bytes caused by one input request.
	task automatic predict_decode(input in_req_t req);
		bit [7:0] pend[$];
		bit [7:0] res[$];
		bit [7:0] c;
		int unsigned cp;
		out_req_t o;
		pend.push_back(req.in_byte);
		forever begin
			if (pend.size() > 0) begin
				c = pend.pop_front();
				if (!amp_open) begin
					if (c == CH_AMP) begin
						amp_open = 1;
						body_len = 0;
					end else begin
						res.push_back(c);
					end
				end else if (c == CH_SEMI) begin
					cp = body_code_point();
					if (cp != 0) begin
						push_utf8(cp, res);
						amp_open = 0;
						body_len = 0;
					end else begin
						abandon_ref(1, c, pend, res);
					end
				end else if (body_len < SPAN - 1) begin
					body_bytes[body_len] = c;
					body_len++;
				end else begin
					abandon_ref(1, c, pend, res);
				end
			end else if (req.in_last && amp_open) begin
				abandon_ref(0, 8'h00, pend, res);
			end else begin
				break;
			end
		end
		for (int i = 0; i < res.size() && i < 16; i++) begin
			o.out_byte = res[i];
			o.out_last = req.in_last && (i == res.size() - 1 || i == 15);
			decoded_q.push_back(o);
		end
	endtask

	function automatic int random_gap();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// Sends one byte request and waits for it to be accepted.
	// Valid stays high afterwards so that the next request can follow at once.
	task automatic send_byte(input bit [7:0] b, input bit last_flag, input bit gaps);
		int gap;
		gap = gaps ? random_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_req.in_byte <= b;
		in_req.in_last <= last_flag;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_decode('{in_byte: b, in_last: last_flag});
		bytes_sent++;
	endtask

	task automatic send_text(input string s, input bit last_flag, input bit gaps);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], last_flag && i == s.len() - 1, gaps);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (decoded_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Random content drawn from reference-shaped fragments and noise.
	function automatic string random_fragment();
		string names[24] = '{"amp", "lt", "gt", "quot", "apos", "nbsp", "hellip", "mdash",
			"ndash", "rsquo", "lsquo", "ldquo", "rdquo", "middot", "deg", "times",
			"copy", "trade", "reg", "eacute", "egrave", "bull", "prime", "Prime"};
		string s;
		case ($urandom_range(0, 7))
			0: s = {"&", names[$urandom_range(0, 23)], ";"};
			1: s = $sformatf("&#%0d;", $urandom_range(0, 'h110100));
			2: s = $sformatf("&#x%0h;", $urandom_range(0, 'h110100));
			3: s = $sformatf("&#X 0x%0H;", $urandom_range(1, 'hFFFF));
			4: s = {"&", names[$urandom_range(0, 23)]};
			5: s = "&#+-12;";
			6: begin
				s = "&";
				repeat ($urandom_range(1, 14)) s = {s, string'(8'($urandom_range(32, 126)))};
			end
			default: begin
				s = "";
				repeat ($urandom_range(1, 4)) s = {s, string'(8'($urandom_range(0, 255)))};
			end
		endcase
		return s;
	endfunction

	// Test: extremes of the byte field and plain pass-through.
	task automatic test_plain_bytes();
		send_byte(8'h00, 0, 0);
		send_byte(8'hFF, 0, 0);
		send_byte(8'h55, 0, 0);
		send_byte(8'hAA, 1, 0);
		wait_drained();
	endtask

	// Test: named, decimal and hex references plus each special case.
	task automatic test_directed_refs();
		send_text("&hellip;&#65;&#x10FFFF;", 1, 0);
		send_text("&#xD800;&#X 0x7f;&# +9;&#-5;&#0;&#1114112;", 1, 0);
		send_text("&abcdefghijkl;&&amp;&lt", 1, 0);
		wait_drained();
	endtask

	// Test: long receiver hold-off while the sender keeps offering requests.
	task automatic test_backpressure();
		hold_off = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			send_text("&copy;&trade;&#x1F600;plain&bull;", 1, 0);
		join
		wait_drained();
	endtask

	// Test: random streams of well-formed and malformed references and noise.
	task automatic test_random_stream(input int target);
		string s;
		int sent_before;
		sent_before = bytes_sent;
		while (bytes_sent - sent_before < target) begin
			s = random_fragment();
			send_text(s, $urandom_range(0, 5) == 0, 1);
			if ($urandom_range(0, 40) == 0) wait_drained();
		end
		send_byte(8'h2E, 1, 1);
		wait_drained();
	endtask

	// Receiver stall generation.
	initial begin
		int gap;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
			end else if (rx_random && $urandom_range(0, 3) == 0) begin
				gap = random_gap();
				if (gap > 0) begin
					out_stall <= 1'b1;
					repeat (gap) @(posedge clk);
				end
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		out_req_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			bytes_checked++;
			if (decoded_q.size() == 0) begin
				report_error($sformatf("unexpected byte %h", out_req.out_byte));
			end else begin
				exp_r = decoded_q.pop_front();
				if (out_req.out_byte !== exp_r.out_byte)
					report_error($sformatf("out_byte %h, expected %h",
						out_req.out_byte, exp_r.out_byte));
				if (out_req.out_last !== exp_r.out_last)
					report_error($sformatf("out_last %b, expected %b",
						out_req.out_last, exp_r.out_last));
			end
		end
	end

	// Watchdog on cycles without any accepted request.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with %0d bytes outstanding", decoded_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_req = '0;
		hold_off = 0;
		rx_random = 0;
		amp_open = 0;
		body_len = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_bytes();
		test_directed_refs();
		test_backpressure();
		rx_random = 1;
		test_random_stream(340);
		$display("Sent %0d bytes and checked %0d decoded bytes,", bytes_sent, bytes_checked);
		$display("covering named, numeric, failed and overlong references under stalls.");
		if (error_count == 0 && decoded_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/hed_pkg.sv
design/hed_front.sv
design/hed_cmdq.sv
design/hed_back.sv
design/html_entity_decoder_unit.sv
bench/html_entity_decoder_unit_tb.sv
